// File: sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants for the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

endpackage

// File: sv/dda_if.sv
// ----------------------------------------------------------------------------
// dda_item_if / dda_pixel_if
// Valid/ready channels for input items and emitted pixels.
// ----------------------------------------------------------------------------
interface dda_item_if import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_pixel_if import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// File: sv/dda_fifo.sv
// ----------------------------------------------------------------------------
// dda_fifo
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module dda_fifo import dda_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// File: sv/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider for the slope: quotient = (num << FRAC_BITS) / den,
// with num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dda_div import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] num,
    input  logic [COORD_BITS-1:0] den,
    output logic                  done,
    output logic [FRAC_BITS:0]    quot
);
    localparam int STEPS = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COORD_BITS:0]   rem_reg;
    logic [COORD_BITS-1:0] den_reg;
    logic [FRAC_BITS:0]    quot_reg;
    logic                  ge;
    logic [COORD_BITS:0]   rem_sub;

    assign ge      = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
    assign done    = done_reg;
    assign quot    = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= {rem_sub[COORD_BITS-1:0], 1'b0};
                quot_reg <= {quot_reg[FRAC_BITS-1:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// File: sv/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Accepts items; for a start item picks the major axis, orders the
// endpoints and forms the deltas handed to the back end.
// ----------------------------------------------------------------------------
module dda_front import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    dda_item_if.sink                   item,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output logic [5*COORD_BITS+2:0]    cmd
);
    typedef struct packed {
        logic                  is_start;
        logic                  x_major;
        logic                  dmin_neg;
        logic [COORD_BITS-1:0] maj0;
        logic [COORD_BITS-1:0] maj1;
        logic [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0] dmaj;
        logic [COORD_BITS-1:0] dmin;
    } cmd_t;

    cmd_t                cmd_w;
    logic [COORD_BITS:0] dx;
    logic [COORD_BITS:0] dy;
    logic [COORD_BITS:0] ndx;
    logic [COORD_BITS:0] ndy;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                dx_neg;
    logic                dy_neg;

    assign dx     = {1'b0, item.x_end} - {1'b0, item.x_start};
    assign dy     = {1'b0, item.y_end} - {1'b0, item.y_start};
    assign ndx    = -dx;
    assign ndy    = -dy;
    assign dx_neg = dx[COORD_BITS];
    assign dy_neg = dy[COORD_BITS];
    assign adx    = dx_neg ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady    = dy_neg ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    always_comb
    begin
        cmd_w          = '0;
        cmd_w.is_start = (item.func == FUNC_START);
        cmd_w.x_major  = (ady <= adx);
        cmd_w.dmin_neg = dx_neg ^ dy_neg;
        if (cmd_w.x_major)
        begin
            cmd_w.maj0 = dx_neg ? item.x_end : item.x_start;
            cmd_w.maj1 = dx_neg ? item.x_start : item.x_end;
            cmd_w.min0 = dx_neg ? item.y_end : item.y_start;
            cmd_w.dmaj = adx;
            cmd_w.dmin = ady;
        end
        else
        begin
            cmd_w.maj0 = dy_neg ? item.y_end : item.y_start;
            cmd_w.maj1 = dy_neg ? item.y_start : item.y_end;
            cmd_w.min0 = dy_neg ? item.x_end : item.x_start;
            cmd_w.dmaj = ady;
            cmd_w.dmin = adx;
        end
    end

    assign cmd        = cmd_w;
    assign cmd_valid  = item.valid;
    assign item.ready = cmd_ready;
endmodule

// File: sv/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Runs queued commands: loads a line (slope via dda_div) or steps it,
// emitting pixels through an output register.
// ----------------------------------------------------------------------------
module dda_back import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  logic [5*COORD_BITS+2:0]    cmd,
    dda_pixel_if.source                pixel
);
    localparam int ACC_W  = COORD_BITS + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;

    typedef struct packed {
        logic                  is_start;
        logic                  x_major;
        logic                  dmin_neg;
        logic [COORD_BITS-1:0] maj0;
        logic [COORD_BITS-1:0] maj1;
        logic [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0] dmaj;
        logic [COORD_BITS-1:0] dmin;
    } cmd_t;

    typedef enum logic {S_RUN, S_DIV} state_t;

    cmd_t                  cmd_w;
    state_t                state_reg;
    logic                  active_reg;
    logic                  x_major_reg;
    logic                  neg_reg;
    logic [COORD_BITS-1:0] pos_reg;
    logic [COORD_BITS-1:0] stop_reg;
    logic [ACC_W-1:0]      accum_reg;     // biased by half an LSB for rounding
    logic [STEP_W-1:0]     step_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_last_reg;

    logic                  out_free;
    logic                  pop;
    logic                  pop_start;
    logic                  emit;
    logic                  div_start;
    logic                  div_done;
    logic [FRAC_BITS:0]    div_quot;
    logic [STEP_W-1:0]     quot_ext;
    logic [COORD_BITS-1:0] pos_next;
    logic [ACC_W-1:0]      accum_next;
    logic [COORD_BITS-1:0] minor;
    logic                  last;

    assign cmd_w     = cmd;
    assign out_free  = !out_valid_reg || pixel.ready;
    assign cmd_ready = (state_reg == S_RUN) && (cmd_w.is_start || out_free);
    assign pop       = cmd_valid && cmd_ready;
    assign pop_start = pop && cmd_w.is_start;
    assign emit      = pop && !cmd_w.is_start && active_reg;
    assign div_start = pop_start && (cmd_w.dmaj != '0);

    assign quot_ext   = {1'b0, div_quot};
    assign pos_next   = pos_reg + 1'b1;
    assign accum_next = accum_reg + {{(COORD_BITS-2){step_reg[STEP_W-1]}}, step_reg};
    assign minor      = accum_next[ACC_W-1:FRAC_BITS];
    assign last       = (pos_next == stop_reg);

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (cmd_w.dmin),
        .den   (cmd_w.dmaj),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            active_reg    <= 1'b0;
            x_major_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            accum_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RUN:
                begin
                    if (pop_start)
                    begin
                        active_reg  <= 1'b0;
                        x_major_reg <= cmd_w.x_major;
                        neg_reg     <= cmd_w.dmin_neg;
                        pos_reg     <= cmd_w.maj0;
                        stop_reg    <= cmd_w.maj1;
                        accum_reg   <= {cmd_w.min0, 1'b1, {(FRAC_BITS-1){1'b0}}};
                        step_reg    <= '0;
                        if (div_start)
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                    else if (emit)
                    begin
                        pos_reg       <= pos_next;
                        accum_reg     <= accum_next;
                        active_reg    <= !last;
                        out_x_reg     <= x_major_reg ? pos_next : minor;
                        out_y_reg     <= x_major_reg ? minor : pos_next;
                        out_last_reg  <= last;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        step_reg   <= neg_reg ? -quot_ext : quot_ext;
                        active_reg <= 1'b1;
                        state_reg  <= S_RUN;
                    end
                end
                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

    assign pixel.valid      = out_valid_reg;
    assign pixel.pixel_x    = out_x_reg;
    assign pixel.pixel_y    = out_y_reg;
    assign pixel.last_pixel = out_last_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("slope result arrived outside of line setup");

    a_active_short_of_stop: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (pos_reg != stop_reg))
        else $error("active line already at its far endpoint");

    a_active_fall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> ($past(pop_start) || $past(emit && last)))
        else $error("line dropped without a start or a last pixel");

    a_slope_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_quot <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("slope magnitude above one");
endmodule

// File: sv/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: start items load endpoints and a fixed-point slope,
// step items emit one pixel each along the major axis while a line is active.
//
//   channel  dir  handshake     payload
//   item     in   valid/ready   func, x_start, y_start, x_end, y_end
//   pixel    out  valid/ready   pixel_x, pixel_y, last_pixel
//
// Step items run at one per cycle while the pixel channel keeps up.
// A start item with distinct endpoints holds the back end while the
// bit-serial slope divider runs; the front keeps queueing items meanwhile.
// A 4-entry command queue separates front and back; the pixel register
// lets a new step proceed in the same cycle the previous pixel is taken.
// Reset (rst_n, async low) clears the line and empties the queue.
// ----------------------------------------------------------------------------
module dda_line_rasterizer import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dda_item_if.sink    item,
    dda_pixel_if.source pixel
);
    localparam int CMD_W = 5 * COORD_BITS + 3;

    logic             fr_valid;
    logic             fr_ready;
    logic [CMD_W-1:0] fr_cmd;
    logic             bk_valid;
    logic             bk_ready;
    logic [CMD_W-1:0] bk_cmd;

    dda_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .item      (item),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    dda_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_cmd),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_data  (bk_cmd)
    );

    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (bk_valid),
        .cmd_ready (bk_ready),
        .cmd       (bk_cmd),
        .pixel     (pixel)
    );
endmodule

// File: tb/dda_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb
// Drives start and step beats into the line rasterizer and checks every pixel
// beat against the bench's fixed-point DDA predictor or a typed pixel. A short
// directed table covers the corner lines. Random lines follow, mostly short and
// fully stepped, both channels stalling at random, and one long sink hold-off.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;
    import dda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB              = COORD_BITS_DEF;
    localparam int FB              = FRAC_BITS_DEF;
    localparam int AW              = CB + FB;
    localparam int COORD_MAX       = (1 << CB) - 1;
    localparam int LONG_LEN        = 127;
    localparam int RANDOM_ITEMS    = 520;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 3 * (FB + 3) + 20;
    localparam int CYCLE_LIMIT     = 800_000;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        logic   func;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
    } line_item_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_PIXEL,
        ROW_PIXEL
    } row_kind_t;

    typedef struct {
        line_item_t item;
        row_kind_t  kind;
        pixel_t     px;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dda_item_if  #(.COORD_BITS(CB)) item_ch ();
    dda_pixel_if #(.COORD_BITS(CB)) pixel_ch ();

    dda_line_rasterizer #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .pixel (pixel_ch)
    );

    always #6 clk = ~clk;

    // Line state mirrored by the bench.
    logic                 line_on;
    logic                 x_major;
    coord_t               maj_pos;
    coord_t               maj_stop;
    logic [AW-1:0]        minor_acc;
    logic signed [FB+1:0] minor_inc;

    pixel_t     expected_pixels[$];
    dir_row_t   corner_rows[$];
    int         error_count = 0;
    int         pixel_beats = 0;
    int         line_items  = 0;
    int         cycle_count = 0;
    bit         tx_burst    = 1'b0;
    bit         rx_burst    = 1'b0;
    bit         held_off    = 1'b0;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Returns 1 when the beat emits a pixel.
    function automatic bit rasterize_beat(input line_item_t it, output pixel_t px);
        int      dx;
        int      dy;
        int      adx;
        int      ady;
        int      dmaj;
        int      dmin;
        coord_t  maj0;
        coord_t  maj1;
        coord_t  min0;
        coord_t  minor;
        longint  mag;

        px = '0;
        if (it.func == FUNC_START) begin
            dx  = int'(it.xe) - int'(it.xs);
            dy  = int'(it.ye) - int'(it.ys);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            x_major = (ady <= adx);
            if (x_major) begin
                if (dx < 0)
                begin
                    maj0 = it.xe; maj1 = it.xs; min0 = it.ye; dmaj = -dx; dmin = -dy;
                end
                else
                begin
                    maj0 = it.xs; maj1 = it.xe; min0 = it.ys; dmaj = dx; dmin = dy;
                end
            end
            else
            begin
                if (dy < 0)
                begin
                    maj0 = it.ye; maj1 = it.ys; min0 = it.xe; dmaj = -dy; dmin = -dx;
                end
                else
                begin
                    maj0 = it.ys; maj1 = it.ye; min0 = it.xs; dmaj = dy; dmin = dx;
                end
            end
            maj_pos   = maj0;
            maj_stop  = maj1;
            minor_acc = AW'(min0) << FB;
            if (dmaj == 0)
            begin
                minor_inc = '0;
                line_on   = 1'b0;
            end
            else
            begin
                mag       = (longint'((dmin < 0) ? -dmin : dmin) << FB) / dmaj;
                minor_inc = (FB+2)'((dmin < 0) ? -mag : mag);
                line_on   = 1'b1;
            end
            return 1'b0;
        end
        if (!line_on)
            return 1'b0;

        maj_pos   = maj_pos + 1'b1;
        minor_acc = minor_acc + AW'(minor_inc);
        minor     = coord_t'((longint'(minor_acc) + (longint'(1) << (FB - 1))) >> FB);
        px.last   = (maj_pos == maj_stop);
        if (px.last)
            line_on = 1'b0;
        px.x = x_major ? maj_pos : minor;
        px.y = x_major ? minor : maj_pos;
        return 1'b1;
    endfunction

    task automatic drive_item(input line_item_t it, input row_kind_t kind, input pixel_t typed_px);
        int     gap;
        bit     was_on;
        bit     has_px;
        pixel_t px;

        if ($urandom_range(0, 24) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.func    <= it.func;
        item_ch.x_start <= it.xs;
        item_ch.y_start <= it.ys;
        item_ch.x_end   <= it.xe;
        item_ch.y_end   <= it.ye;
        do @(posedge clk); while (item_ch.ready !== 1'b1);

        was_on = line_on;
        has_px = rasterize_beat(it, px);
        if (kind == ROW_PIXEL)
            expected_pixels.push_back(typed_px);
        else if (kind == ROW_PREDICT && has_px)
            expected_pixels.push_back(px);
        if (it.func == FUNC_START || was_on)
            line_items++;
    endtask

    task automatic add_row(input logic func, input int xs, input int ys, input int xe,
                           input int ye, input row_kind_t kind, input int px, input int py,
                           input logic last);
        dir_row_t r;

        r.item = '{func, coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye)};
        r.kind = kind;
        r.px   = '{coord_t'(px), coord_t'(py), last};
        corner_rows.push_back(r);
    endtask

    function automatic coord_t near_coord(input coord_t c);
        int v;

        v = int'(c) + $urandom_range(0, 24) - 12;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    function automatic line_item_t random_item(input logic func);
        line_item_t it;

        it.func = func;
        it.xs   = coord_t'($urandom);
        it.ys   = coord_t'($urandom);
        it.xe   = coord_t'($urandom);
        it.ye   = coord_t'($urandom);
        return it;
    endfunction

    // Sink: random stalls, stretches with none, and one long hold-off.
    initial
    begin : pixel_sink
        int gap;

        pixel_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 17);
            if (!held_off && pixel_beats >= 60)
            begin
                held_off = 1'b1;
                gap      = HOLD_OFF_CYCLES;
            end
            if (gap != 0)
            begin
                pixel_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pixel_ch.ready <= 1'b1;
            do @(posedge clk); while (pixel_ch.valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;

        if (rst_n && pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1)
        begin
            pixel_beats <= pixel_beats + 1;
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected pixel beat, pixel_x", pixel_ch.pixel_x, -1);
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_ch.pixel_x !== want.x)
                    report_mismatch("pixel_x", pixel_ch.pixel_x, want.x);
                if (pixel_ch.pixel_y !== want.y)
                    report_mismatch("pixel_y", pixel_ch.pixel_y, want.y);
                if (pixel_ch.last_pixel !== want.last)
                    report_mismatch("last_pixel", pixel_ch.last_pixel, want.last);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("dda_line_rasterizer test failed");
        $finish;
    end

    initial
    begin : stimulus
        line_item_t it;
        int         len;
        int         n_steps;
        int         sel;

        rst_n            = 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.func    <= FUNC_STEP;
        item_ch.x_start <= '0;
        item_ch.y_start <= '0;
        item_ch.x_end   <= '0;
        item_ch.y_end   <= '0;
        line_on   = 1'b0;
        x_major   = 1'b0;
        maj_pos   = '0;
        maj_stop  = '0;
        minor_acc = '0;
        minor_inc = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no line, single pixel line, step after the last pixel
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_START, 0, 0, 1, 0, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL,    1, 0, 1'b1);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_NO_PIXEL, 0, 0, 1'b0);
        // full diagonals, tie goes to x; a start replaces a running line
        add_row(FUNC_START, 0, 0, COORD_MAX, COORD_MAX, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL, 1, 1, 1'b0);
        add_row(FUNC_START, COORD_MAX, COORD_MAX, 0, 0, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL, 1, 1, 1'b0);
        add_row(FUNC_START, 0, COORD_MAX, COORD_MAX, 0, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL, 1, COORD_MAX - 1, 1'b0);
        // equal endpoints
        add_row(FUNC_START, 5, 5, 5, 5, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_NO_PIXEL, 0, 0, 1'b0);
        // y major, fractional slope
        add_row(FUNC_START, 0, 0, 1, 3, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PREDICT, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PREDICT, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL, 1, 3, 1'b1);
        // exact half rounds up
        add_row(FUNC_START, 0, 0, 2, 1, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL, 1, 1, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL, 2, 1, 1'b1);
        // negative minor slope, y major
        add_row(FUNC_START, COORD_MAX, 0, COORD_MAX - 7, COORD_MAX, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, ROW_PREDICT,
                0, 0, 1'b0);
        // far endpoint at the top corner, vertical line run backwards
        add_row(FUNC_START, COORD_MAX - 1, COORD_MAX, COORD_MAX, COORD_MAX, ROW_NO_PIXEL,
                0, 0, 1'b0);
        add_row(FUNC_STEP,  0, 0, 0, 0, ROW_PIXEL, COORD_MAX, COORD_MAX, 1'b1);
        add_row(FUNC_START, 0, COORD_MAX, 0, 0, ROW_NO_PIXEL, 0, 0, 1'b0);
        add_row(FUNC_STEP,  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, ROW_PIXEL,
                0, 1, 1'b0);

        foreach (corner_rows[i])
            drive_item(corner_rows[i].item, corner_rows[i].kind, corner_rows[i].px);

        // one long x-major line up to the right edge, stepped to its end
        it      = random_item(FUNC_START);
        it.xs   = coord_t'(COORD_MAX - LONG_LEN);
        it.xe   = coord_t'(COORD_MAX);
        it.ys   = coord_t'($urandom_range(0, LONG_LEN));
        it.ye   = coord_t'($urandom_range(0, LONG_LEN));
        line_items = 0;
        drive_item(it, ROW_PREDICT, '0);
        repeat (LONG_LEN)
            drive_item(random_item(FUNC_STEP), ROW_PREDICT, '0);

        line_items = 0;
        while (line_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
            begin
                repeat ($urandom_range(1, 4))
                    drive_item(random_item(logic'($urandom_range(0, 1))), ROW_PREDICT, '0);
            end
            else
            begin
                it = random_item(FUNC_START);
                if (sel > 2)
                begin
                    it.xe = near_coord(it.xs);
                    it.ye = near_coord(it.ys);
                end
                drive_item(it, ROW_PREDICT, '0);
                len = int'(maj_stop) - int'(maj_pos);
                if (!line_on)
                    len = 0;
                if (len > 40)
                    n_steps = $urandom_range(0, 40);
                else if ($urandom_range(0, 4) == 0)
                    n_steps = $urandom_range(0, len);
                else
                    n_steps = len + $urandom_range(0, 2);
                repeat (n_steps)
                    drive_item(random_item(FUNC_STEP), ROW_PREDICT, '0);
            end
        end

        item_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("dda_line_rasterizer test passed");
        else
            $display("dda_line_rasterizer test failed");
        $finish;
    end

endmodule
